### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers with asynchronous reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression never true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

### src/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg
// types and constants of the counting semaphore with fifo wait queue
// ----------------------------------------------------------------------------
package csem_pkg;

	localparam int QueueDepth   = 16;
	localparam int ThreadIdBits = 8;
	localparam int CountBits    = 16;
	localparam int InitBits     = 15;

	localparam logic signed [CountBits-1:0] CountMax = 16'sd32767;

	typedef enum logic [1:0] {
		OP_WAIT   = 2'd0,
		OP_SIGNAL = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_OPEN   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BLOCKED  = 2'd1,
		ST_CLOSED   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE  = 1'b0,
		FSM_DRAIN = 1'b1
	} fsm_t;

	// command broadcast to every queue cell
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} cell_cmd_t;

endpackage

### src/csem_if.sv
// ----------------------------------------------------------------------------
// csem interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface csem_req_if #(
	parameter int ID_BITS = csem_pkg::ThreadIdBits
);
	logic               valid;
	logic               ready;
	csem_pkg::op_t      op;
	logic [ID_BITS-1:0] thread_id;

	modport source (output valid, output op, output thread_id, input ready);
	modport sink (input valid, input op, input thread_id, output ready);
endinterface

interface csem_rsp_if #(
	parameter int ID_BITS = csem_pkg::ThreadIdBits
);
	logic               valid;
	logic               ready;
	csem_pkg::status_t  status;
	logic               woken_valid;
	logic [ID_BITS-1:0] woken_thread;
	logic               last;

	modport source (output valid, output status, output woken_valid, output woken_thread,
		output last, input ready);
	modport sink (input valid, input status, input woken_valid, input woken_thread,
		input last, output ready);
endinterface

### src/csem_cell.sv
// ----------------------------------------------------------------------------
// csem_cell
// one slot of the shifting wait queue; pop moves every entry one slot
// toward the head, push fills the first empty slot behind a full one
// ----------------------------------------------------------------------------
module csem_cell #(
	parameter int ID_BITS = csem_pkg::ThreadIdBits
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csem_pkg::cell_cmd_t cmd,
	input  logic [ID_BITS-1:0]  push_id,
	input  logic                prev_valid,
	input  logic                next_valid,
	input  logic [ID_BITS-1:0]  next_id,
	output logic                valid,
	output logic [ID_BITS-1:0]  id
);
	import csem_pkg::*;

	logic               valid_q;
	logic [ID_BITS-1:0] id_q;
	logic               take_push;

	assign take_push = cmd.push && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= next_valid;
		end else if (take_push) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			id_q <= next_id;
		end else if (take_push) begin
			id_q <= push_id;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
endmodule

### src/counting_semaphore_wait_queue.sv
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// counting semaphore with a fifo of blocked thread ids held in a row of cells
// ----------------------------------------------------------------------------
// channel  dir  payload                                        handshake
// req      in   op, thread_id                                  valid/ready
// rsp      out  status, woken_valid, woken_thread, last        valid/ready
// cfg      in   cfg_data (initial_count)                       cfg_we
//
// wait, signal and open each give one response
// close gives one response per queued waiter, or a single one when none wait
// a request enters only when the response slot is empty or being taken
// a stalled rsp holds the slot; requests are refused during a close drain
// reset clears count, closed flag, queue and initial_count
module counting_semaphore_wait_queue #(
	parameter int QUEUE_DEPTH    = csem_pkg::QueueDepth,
	parameter int THREAD_ID_BITS = csem_pkg::ThreadIdBits
) (
	input  logic                            clk,
	input  logic                            arst_n,
	csem_req_if.sink                        req,
	csem_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [csem_pkg::InitBits-1:0]   cfg_data
);
	import csem_pkg::*;

	fsm_t                            state_q, state_d;
	logic signed [CountBits-1:0]     count_q, count_d, count_inc;
	logic                            closed_q, closed_d;
	logic [InitBits-1:0]             init_q;

	logic                            rsp_valid_q;
	status_t                         rsp_status_q;
	logic                            rsp_woken_valid_q;
	logic [THREAD_ID_BITS-1:0]       rsp_woken_thread_q;
	logic                            rsp_last_q;

	cell_cmd_t                       cmd;
	logic                            slot_free, acc, drain_step;
	logic                            emit, e_wv, e_last;
	status_t                         e_status;
	logic [THREAD_ID_BITS-1:0]       e_wid;

	logic [QUEUE_DEPTH-1:0]          cell_valid;
	logic [THREAD_ID_BITS-1:0]       cell_id [QUEUE_DEPTH];

	// wait queue chain, cell 0 is the head
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                      prev_v;
		logic                      next_v;
		logic [THREAD_ID_BITS-1:0] next_id;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_v  = 1'b0;
			assign next_id = '0;
		end else begin : g_link
			assign next_v  = cell_valid[i+1];
			assign next_id = cell_id[i+1];
		end

		csem_cell #(
			.ID_BITS(THREAD_ID_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_id    (req.thread_id),
			.prev_valid (prev_v),
			.next_valid (next_v),
			.next_id    (next_id),
			.valid      (cell_valid[i]),
			.id         (cell_id[i])
		);
	end

	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign req.ready  = (state_q == FSM_IDLE) && slot_free;
	assign acc        = req.valid && req.ready;
	assign drain_step = (state_q == FSM_DRAIN) && slot_free;
	assign count_inc  = (count_q != CountMax) ? count_q + 16'sd1 : count_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (acc && req.op == OP_CLOSE && cell_valid[0]) begin
					state_d = FSM_DRAIN;
				end
			end
			FSM_DRAIN: begin
				if (drain_step && !cell_valid[1]) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	// actions and response
	always_comb begin
		cmd      = '0;
		emit     = 1'b0;
		e_status = ST_OK;
		e_wv     = 1'b0;
		e_wid    = '0;
		e_last   = 1'b1;
		count_d  = count_q;
		closed_d = closed_q;
		if (acc) begin
			emit = 1'b1;
			unique case (req.op)
				OP_WAIT: begin
					if (closed_q) begin
						e_status = ST_CLOSED;
					end else if (count_q > 16'sd0) begin
						count_d = count_q - 16'sd1;
					end else if (cell_valid[QUEUE_DEPTH-1]) begin
						e_status = ST_OVERFLOW;
					end else begin
						count_d  = count_q - 16'sd1;
						cmd.push = 1'b1;
						e_status = ST_BLOCKED;
					end
				end
				OP_SIGNAL: begin
					if (closed_q) begin
						e_status = ST_CLOSED;
					end else begin
						count_d = count_inc;
						if (count_inc <= 16'sd0 && cell_valid[0]) begin
							cmd.pop = 1'b1;
							e_wv    = 1'b1;
							e_wid   = cell_id[0];
						end
					end
				end
				OP_CLOSE: begin
					closed_d = 1'b1;
					emit     = !cell_valid[0];
				end
				OP_OPEN: begin
					count_d   = signed'({1'b0, init_q});
					closed_d  = 1'b0;
					cmd.clear = 1'b1;
				end
				default: ;
			endcase
		end
		if (drain_step) begin
			cmd.pop = 1'b1;
			emit    = 1'b1;
			e_wv    = 1'b1;
			e_wid   = cell_id[0];
			e_last  = !cell_valid[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			closed_q    <= 1'b0;
			init_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			closed_q <= closed_d;
			if (cfg_we) begin
				init_q <= cfg_data;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q       <= e_status;
			rsp_woken_valid_q  <= e_wv;
			rsp_woken_thread_q <= e_wid;
			rsp_last_q         <= e_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.woken_valid  = rsp_woken_valid_q;
	assign rsp.woken_thread = rsp_woken_thread_q;
	assign rsp.last         = rsp_last_q;
endmodule

### src/csem_chk.sv
// ----------------------------------------------------------------------------
// csem_chk
// port level checks of the semaphore responses, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csem_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input csem_pkg::status_t rsp_status,
	input logic              rsp_woken_valid,
	input logic              rsp_last
);
	import csem_pkg::*;

	// response holds while stalled
	`ASSERT_CLK(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
	// a released waiter always carries status ok
	`ASSERT_NEVER(a_wake_ok, clk, arst_n, rsp_valid && rsp_woken_valid && rsp_status != ST_OK, "bad wake status")
	// only close drain results may be non-final
	`ASSERT_NEVER(a_mid_wake, clk, arst_n, rsp_valid && !rsp_last && !rsp_woken_valid, "non-final without wake")
	// no request taken while a drain is under way
	`ASSERT_NEVER(a_drain_busy, clk, arst_n, rsp_valid && !rsp_last && req_ready, "ready during drain")
endmodule

bind counting_semaphore_wait_queue csem_chk u_csem_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_woken_valid (rsp.woken_valid),
	.rsp_last        (rsp.last)
);

### verif/csem_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_checker
// watches the request, response and config ports of the counting semaphore,
// keeps its own copy of count, closed flag and waiter fifo, and compares every
// response field with the oldest outcome predicted from accepted requests
// ----------------------------------------------------------------------------
module csem_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	csem_req_if                           req,
	csem_rsp_if                           rsp,
	input  logic                          cfg_we,
	input  logic [csem_pkg::InitBits-1:0] cfg_data,
	output int unsigned                   pending,
	output int unsigned                   failures
);
	import csem_pkg::*;

	typedef struct packed {
		status_t                 status;
		logic                    woken_valid;
		logic [ThreadIdBits-1:0] woken_thread;
		logic                    last;
	} sem_result_t;

	sem_result_t                 outcome_q[$];
	logic signed [CountBits-1:0] count_m;
	logic                        closed_m;
	logic [ThreadIdBits-1:0]     waiters_m[QueueDepth];
	int unsigned                 head_m;
	int unsigned                 tail_m;
	int unsigned                 fill_m;
	logic [InitBits-1:0]         reload_m;
	int unsigned                 bad_cnt = 0;

	assign failures = bad_cnt;

	function automatic void queue_outcome(status_t st, logic wv, logic [ThreadIdBits-1:0] wt,
		logic lst);
		sem_result_t r;
		r.status       = st;
		r.woken_valid  = wv;
		r.woken_thread = wt;
		r.last         = lst;
		outcome_q.push_back(r);
	endfunction

	function automatic logic [ThreadIdBits-1:0] dequeue_waiter();
		logic [ThreadIdBits-1:0] id;
		id     = waiters_m[head_m];
		head_m = (head_m + 1) % QueueDepth;
		fill_m--;
		return id;
	endfunction

	function automatic void predict_semaphore(op_t op, logic [ThreadIdBits-1:0] tid);
		logic [ThreadIdBits-1:0] id;
		case (op)
		OP_WAIT: begin
			if (closed_m) begin
				queue_outcome(ST_CLOSED, 1'b0, '0, 1'b1);
			end else if (count_m > 0) begin
				count_m--;
				queue_outcome(ST_OK, 1'b0, '0, 1'b1);
			end else if (fill_m >= QueueDepth) begin
				queue_outcome(ST_OVERFLOW, 1'b0, '0, 1'b1);
			end else begin
				count_m--;
				waiters_m[tail_m] = tid;
				tail_m = (tail_m + 1) % QueueDepth;
				fill_m++;
				queue_outcome(ST_BLOCKED, 1'b0, '0, 1'b1);
			end
		end
		OP_SIGNAL: begin
			if (closed_m) begin
				queue_outcome(ST_CLOSED, 1'b0, '0, 1'b1);
			end else begin
				if (count_m < CountMax)
					count_m++;
				if (count_m <= 0 && fill_m > 0) begin
					id = dequeue_waiter();
					queue_outcome(ST_OK, 1'b1, id, 1'b1);
				end else begin
					queue_outcome(ST_OK, 1'b0, '0, 1'b1);
				end
			end
		end
		OP_CLOSE: begin
			closed_m = 1'b1;
			if (fill_m == 0)
				queue_outcome(ST_OK, 1'b0, '0, 1'b1);
			while (fill_m > 0) begin
				id = dequeue_waiter();
				queue_outcome(ST_OK, 1'b1, id, fill_m == 0);
			end
		end
		default: begin
			count_m  = $signed({1'b0, reload_m});
			closed_m = 1'b0;
			head_m   = 0;
			tail_m   = 0;
			fill_m   = 0;
			queue_outcome(ST_OK, 1'b0, '0, 1'b1);
		end
		endcase
	endfunction

	function automatic void compare_result();
		sem_result_t want;
		if (outcome_q.size() == 0) begin
			$error("response with no request outstanding: status %0d woken %0d thread %0h",
				rsp.status, rsp.woken_valid, rsp.woken_thread);
			bad_cnt++;
			return;
		end
		want = outcome_q.pop_front();
		if (rsp.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, rsp.status);
			bad_cnt++;
		end
		if (rsp.woken_valid !== want.woken_valid) begin
			$error("woken_valid: expected %0d, actual %0d", want.woken_valid, rsp.woken_valid);
			bad_cnt++;
		end
		if (rsp.woken_thread !== want.woken_thread) begin
			$error("woken_thread: expected %0h, actual %0h", want.woken_thread, rsp.woken_thread);
			bad_cnt++;
		end
		if (rsp.last !== want.last) begin
			$error("last: expected %0d, actual %0d", want.last, rsp.last);
			bad_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_m  = '0;
			closed_m = 1'b0;
			head_m   = 0;
			tail_m   = 0;
			fill_m   = 0;
			reload_m = '0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready)
				compare_result();
			if (req.valid && req.ready)
				predict_semaphore(req.op, req.thread_id);
			if (cfg_we)
				reload_m = cfg_data;
			pending <= outcome_q.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives directed and random semaphore requests with random gaps and response
// stalls outside calm phases, reloads initial_count between phases, and gives
// the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------
module tb;
	import csem_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [InitBits-1:0] cfg_data;
	int unsigned         pending;
	int unsigned         failures;
	bit                  calm;

	csem_req_if req_ch();
	csem_rsp_if rsp_ch();

	counting_semaphore_wait_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	csem_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.pending  (pending),
		.failures (failures)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_request(op_t op, logic [ThreadIdBits-1:0] tid);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.thread_id <= tid;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reload(logic [InitBits-1:0] value);
		settle();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
		@(posedge clk);
	endtask

	// response side
	initial begin
		int unsigned stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	initial begin
		int unsigned         wait_pct;
		int unsigned         roll;
		op_t                 op;
		op_t                 last_op;
		logic [InitBits-1:0] reload;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_WAIT;
		req_ch.thread_id <= '0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: block, wake, proceed, fill to overflow, close drain, refusals
		write_reload('0);
		send_request(OP_WAIT, 8'hFF);
		send_request(OP_SIGNAL, 8'h00);
		send_request(OP_SIGNAL, 8'h00);
		send_request(OP_WAIT, 8'h00);
		for (int i = 0; i < QueueDepth; i++)
			send_request(OP_WAIT, ThreadIdBits'(i * 17));
		send_request(OP_WAIT, 8'h5A);
		send_request(OP_SIGNAL, 8'hA5);
		send_request(OP_CLOSE, 8'h00);
		send_request(OP_WAIT, 8'h81);
		send_request(OP_SIGNAL, 8'h7E);
		send_request(OP_CLOSE, 8'hFF);

		// count saturation
		write_reload('1);
		send_request(OP_OPEN, 8'h00);
		send_request(OP_SIGNAL, 8'h00);
		send_request(OP_WAIT, 8'h01);
		send_request(OP_SIGNAL, 8'h00);
		send_request(OP_SIGNAL, 8'h00);

		// open with waiters still queued drops them
		write_reload('0);
		send_request(OP_OPEN, 8'h00);
		send_request(OP_WAIT, 8'h3C);
		send_request(OP_WAIT, 8'hC3);
		send_request(OP_OPEN, 8'h00);
		send_request(OP_SIGNAL, 8'h00);

		last_op = OP_OPEN;
		for (int p = 0; p < 10; p++) begin
			case (p)
			0: reload = '0;
			1: reload = '1;
			2: reload = InitBits'($urandom_range(0, 32767));
			default: reload = InitBits'($urandom_range(0, 4));
			endcase
			write_reload(reload);
			calm     = (p % 3 == 1);
			wait_pct = $urandom_range(40, 65);
			send_request(OP_OPEN, ThreadIdBits'($urandom_range(0, 255)));
			for (int k = 0; k < 42; k++) begin
				roll = $urandom_range(0, 99);
				if (last_op == OP_CLOSE && roll < 70)
					op = OP_OPEN;
				else if (roll < wait_pct)
					op = OP_WAIT;
				else if (roll < 90)
					op = OP_SIGNAL;
				else if (roll < 95)
					op = OP_CLOSE;
				else
					op = OP_OPEN;
				send_request(op, ThreadIdBits'($urandom_range(0, 255)));
				last_op = op;
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
